FILE: sv/tccw_pkg.sv
package tccw_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 30;

  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 8;
  localparam int ACT_W  = 3;

  localparam logic [ACT_W-1:0] ACT_PUT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_GOTO  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUTAT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REV   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_HRUN  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_VRUN  = 3'd6;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd7;

  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_HLINE  = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_VLINE  = 8'h0E;
  localparam logic [CHAR_W-1:0] REVERSE_BIT = 8'h80;

  typedef struct packed {
    logic load;
    logic set_rev;
    logic div_en;
    logic line_en;
    logic line_move;
    logic put;
    logic hrun_step;
    logic vrun_step;
    logic rd_issue;
    logic rd_capture;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic clr_last;
  } stat_t;

  typedef struct packed {
    logic [8:0] quo;
    logic [6:0] rem;
  } divmod_t;

  // Divide by a constant through a 16-bit fixed-point reciprocal. Exact for a
  // nine-bit dividend and a divisor from 2 to 64: the rounding error times the
  // largest dividend stays below 2^16.
  function automatic divmod_t div_small(input logic [8:0] num, input logic [6:0] den,
                                        input logic [15:0] recip);
    divmod_t     res;
    logic [24:0] prod;
    logic [8:0]  back;
    logic [8:0]  diff;
    prod    = {16'b0, num} * {9'b0, recip};
    res.quo = prod[24:16];
    back    = res.quo * {2'b0, den};
    diff    = num - back;
    res.rem = diff[6:0];
    return res;
  endfunction

endpackage

FILE: sv/tccw_ram.sv
module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tccw_ctrl.sv
module tccw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [tccw_pkg::ACT_W-1:0]  action_i,
  input  tccw_pkg::stat_t             stat_i,
  output tccw_pkg::cmd_t              cmd_o,
  output logic                        busy,
  output logic                        done_o
);
  import tccw_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_LINE = 4'd3;
  localparam logic [3:0] S_PUT  = 4'd4;
  localparam logic [3:0] S_HRUN = 4'd5;
  localparam logic [3:0] S_VRUN = 4'd6;
  localparam logic [3:0] S_RDA  = 4'd7;
  localparam logic [3:0] S_RDD  = 4'd8;
  localparam logic [3:0] S_CLR  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.set_rev = (action_i == ACT_REV);
          act_d         = action_i;
          unique case (action_i)
            ACT_PUT:   state_d = S_PUT;
            ACT_CLEAR: state_d = S_CLR;
            ACT_REV:   state_d = S_DONE;
            default:   state_d = S_DIV;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = S_LINE;
      end
      S_LINE: begin
        cmd_o.line_en   = 1'b1;
        cmd_o.line_move = (act_q != ACT_READ);
        unique case (act_q)
          ACT_PUTAT: state_d = S_PUT;
          ACT_HRUN:  state_d = S_HRUN;
          ACT_VRUN:  state_d = S_VRUN;
          ACT_READ:  state_d = S_RDA;
          default:   state_d = S_DONE;
        endcase
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_HRUN: begin
        if (stat_i.cnt_zero) state_d = S_DONE;
        else cmd_o.hrun_step = 1'b1;
      end
      S_VRUN: begin
        if (stat_i.cnt_zero) state_d = S_DONE;
        else cmd_o.vrun_step = 1'b1;
      end
      S_RDA: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RDD;
      end
      S_RDD: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      act_q   <= ACT_PUT;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

FILE: sv/tccw_datapath.sv
module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tccw_pkg::cmd_t               cmd_i,
  output tccw_pkg::stat_t              stat_o,
  input  logic [7:0]                   col_i,
  input  logic [7:0]                   row_i,
  input  logic [tccw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tccw_pkg::CNT_W-1:0]   count_i,
  input  logic                         reverse_on_i,
  output logic [tccw_pkg::POS_W-1:0]   cursor_col_o,
  output logic [tccw_pkg::POS_W-1:0]   cursor_row_o,
  output logic [tccw_pkg::CHAR_W-1:0]  read_char_o,
  output logic [3:0]                   glyph_col_o,
  output logic [3:0]                   glyph_row_o
);
  import tccw_pkg::*;

  localparam int DEPTH     = COLUMNS * ROWS;
  localparam int AW        = $clog2(DEPTH);
  localparam int COL_RECIP = (65536 + COLUMNS - 1) / COLUMNS;
  localparam int ROW_RECIP = (65536 + ROWS - 1) / ROWS;

  // latched request fields
  logic [7:0]        col_q, row_q;
  logic [CHAR_W-1:0] ch_q;
  logic              rev_q, rev_d;

  logic [7:0]        quo_q;
  logic [POS_W-1:0]  tcol_q;
  logic [POS_W-1:0]  vbase_q;
  logic [POS_W-1:0]  vline_q, vline_d;
  logic [7:0]        vrow_q, vrow_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [CHAR_W-1:0] rd_char_q, rd_char_d;
  logic [POS_W-1:0]  cur_col_q, cur_col_d;
  logic [POS_W-1:0]  cur_line_q, cur_line_d;

  divmod_t           col_div, line_div, base_div;
  logic              use_v;
  logic [POS_W-1:0]  src_col, src_line;
  logic [POS_W:0]    col_inc, line_inc_w;
  logic [POS_W-1:0]  line_inc, adv_col, adv_line;
  logic [AW-1:0]     pos_addr, waddr;
  logic              is_ctl_char, we;
  logic [CHAR_W-1:0] rev_mask, wdata, rdata;

  assign col_div  = div_small({1'b0, col_q}, 7'(COLUMNS), 16'(COL_RECIP));
  assign line_div = div_small({1'b0, row_q} + {1'b0, quo_q}, 7'(ROWS), 16'(ROW_RECIP));
  assign base_div = div_small({1'b0, quo_q}, 7'(ROWS), 16'(ROW_RECIP));

  // position source: cursor, or the fixed column with the run line
  assign use_v    = cmd_i.vrun_step | cmd_i.rd_issue;
  assign src_col  = use_v ? tcol_q : cur_col_q;
  assign src_line = use_v ? vline_q : cur_line_q;
  assign pos_addr = AW'(src_col) + AW'(src_line) * AW'(COLUMNS);

  assign col_inc    = {1'b0, src_col} + 1'b1;
  assign line_inc_w = {1'b0, src_line} + 1'b1;
  assign line_inc   = (line_inc_w == (POS_W+1)'(ROWS)) ? '0 : line_inc_w[POS_W-1:0];
  assign adv_col    = (col_inc == (POS_W+1)'(COLUMNS)) ? '0 : col_inc[POS_W-1:0];
  assign adv_line   = (col_inc == (POS_W+1)'(COLUMNS)) ? line_inc : src_line;

  assign is_ctl_char = (ch_q == CHAR_CR) || (ch_q == CHAR_LF);
  assign rev_mask    = rev_q ? REVERSE_BIT : '0;

  always_comb begin
    priority if (cmd_i.clr_step) wdata = CHAR_SPACE;
    else if (cmd_i.vrun_step)    wdata = CHAR_VLINE ^ rev_mask;
    else if (cmd_i.hrun_step)    wdata = CHAR_HLINE ^ rev_mask;
    else                         wdata = ch_q ^ rev_mask;
  end

  assign we    = cmd_i.clr_step | cmd_i.vrun_step | cmd_i.hrun_step |
                 (cmd_i.put & ~is_ctl_char);
  assign waddr = cmd_i.clr_step ? clr_cnt_q : pos_addr;

  tccw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (pos_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    cur_col_d  = cur_col_q;
    cur_line_d = cur_line_q;
    priority if (cmd_i.clr_step) begin
      cur_col_d  = '0;
      cur_line_d = '0;
    end else if (cmd_i.line_en && cmd_i.line_move) begin
      cur_col_d  = tcol_q;
      cur_line_d = line_div.rem[POS_W-1:0];
    end else if (cmd_i.put) begin
      priority if (ch_q == CHAR_CR) begin
        cur_col_d = '0;
      end else if (ch_q == CHAR_LF) begin
        cur_line_d = line_inc;
      end else begin
        cur_col_d  = adv_col;
        cur_line_d = adv_line;
      end
    end else if (cmd_i.hrun_step || cmd_i.vrun_step) begin
      cur_col_d  = adv_col;
      cur_line_d = adv_line;
    end
  end

  always_comb begin
    vline_d   = vline_q;
    vrow_d    = vrow_q;
    cnt_d     = cnt_q;
    clr_cnt_d = clr_cnt_q;
    rd_char_d = rd_char_q;
    rev_d     = cmd_i.set_rev ? reverse_on_i : rev_q;
    if (cmd_i.load) begin
      cnt_d     = count_i;
      rd_char_d = '0;
    end
    if (cmd_i.line_en) begin
      vline_d = line_div.rem[POS_W-1:0];
      vrow_d  = row_q;
    end
    if (cmd_i.vrun_step) begin
      // the run row wraps at 256, where the line restarts from the column carry
      vline_d = (vrow_q == 8'hFF) ? vbase_q : line_inc;
      vrow_d  = vrow_q + 8'd1;
    end
    if (cmd_i.hrun_step || cmd_i.vrun_step) cnt_d = cnt_q - 1'b1;
    if (cmd_i.clr_step) begin
      clr_cnt_d = stat_o.clr_last ? '0 : clr_cnt_q + 1'b1;
    end
    if (cmd_i.rd_capture) rd_char_d = rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_line_q <= '0;
      rev_q      <= 1'b0;
      clr_cnt_q  <= '0;
      cnt_q      <= '0;
      rd_char_q  <= '0;
    end else begin
      cur_col_q  <= cur_col_d;
      cur_line_q <= cur_line_d;
      rev_q      <= rev_d;
      clr_cnt_q  <= clr_cnt_d;
      cnt_q      <= cnt_d;
      rd_char_q  <= rd_char_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= col_i;
      row_q <= row_i;
      ch_q  <= char_code_i;
    end
    if (cmd_i.div_en) begin
      quo_q  <= col_div.quo[7:0];
      tcol_q <= col_div.rem[POS_W-1:0];
    end
    if (cmd_i.line_en) begin
      vbase_q <= base_div.rem[POS_W-1:0];
    end
    vline_q <= vline_d;
    vrow_q  <= vrow_d;
  end

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

  assign cursor_col_o = cur_col_q;
  assign cursor_row_o = cur_line_q;
  assign read_char_o  = rd_char_q;
  assign glyph_col_o  = rd_char_q[3:0];
  assign glyph_row_o  = rd_char_q[7:4];

endmodule

FILE: sv/text_console_cursor_writer.sv
// Text console with a COLUMNS x ROWS screen store, a cursor and reverse video.
// Issue a request by raising start with action_i and its fields while busy is
// low; the request is taken at that clock edge and busy rises the cycle after.
// Each request yields one result: done_o is high for exactly one cycle with
// the cursor position, and for a read the stored byte and its glyph tile.
// The receiver cannot stall; the result ports hold their values until the
// next request changes them. busy drops the cycle after done_o.
// Steps from the accepting edge to done_o: reverse goes straight to done;
//   put char acts at the cursor; goto divides the column, then wraps the
//   row; put at does so, then writes; read does the column and row wrap,
//   then the registered memory read; a horizontal or vertical run wraps,
//   then writes count cells, one cell written per cycle; clear writes one
//   cell per cycle through the single write port.
// The next request can be taken in the cycle after done_o.
// After reset the block sweeps every cell to a space, one per cycle, and busy
// stays high until the sweep ends; the cursor and reverse mode reset to zero.
module text_console_cursor_writer #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tccw_pkg::ACT_W-1:0]   action_i,
  input  logic [7:0]                   col_i,
  input  logic [7:0]                   row_i,
  input  logic [tccw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tccw_pkg::CNT_W-1:0]   count_i,
  input  logic                         reverse_on_i,
  output logic                         done_o,
  output logic [tccw_pkg::POS_W-1:0]   cursor_col_o,
  output logic [tccw_pkg::POS_W-1:0]   cursor_row_o,
  output logic [tccw_pkg::CHAR_W-1:0]  read_char_o,
  output logic [3:0]                   glyph_col_o,
  output logic [3:0]                   glyph_row_o
);
  import tccw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tccw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  tccw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .col_i        (col_i),
    .row_i        (row_i),
    .char_code_i  (char_code_i),
    .count_i      (count_i),
    .reverse_on_i (reverse_on_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .read_char_o  (read_char_o),
    .glyph_col_o  (glyph_col_o),
    .glyph_row_o  (glyph_row_o)
  );

endmodule

FILE: sv/tccw_checker.sv
module tccw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [tccw_pkg::POS_W-1:0]   cursor_col_o,
  input logic [tccw_pkg::POS_W-1:0]   cursor_row_o,
  input logic [tccw_pkg::CHAR_W-1:0]  read_char_o,
  input logic [3:0]                   glyph_col_o,
  input logic [3:0]                   glyph_row_o
);

  // an accepted request makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but busy stayed low");

  // one result per request: done_o never stays high past its strobe
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe held for more than one cycle");

  // the glyph tile is always the split of the returned byte
  a_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (glyph_col_o == read_char_o[3:0] && glyph_row_o == read_char_o[7:4]))
    else $error("glyph tile does not match read byte");

  // an idle block with no request leaves the cursor alone
  a_cursor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> ($stable(cursor_col_o) && $stable(cursor_row_o)))
    else $error("cursor moved without a request");

endmodule

bind text_console_cursor_writer tccw_checker u_tccw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .cursor_col_o (cursor_col_o),
  .cursor_row_o (cursor_row_o),
  .read_char_o  (read_char_o),
  .glyph_col_o  (glyph_col_o),
  .glyph_row_o  (glyph_row_o)
);
